// ----- design/eight_bit_cpu_alu_with_flags_core_defines.svh -----
// assertion macros for the alu core
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define ALU8F_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alu core check failed");

// next-cycle implication, checked out of reset
`define ALU8F_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alu core check failed");

`else

`define ALU8F_ASSERT_SAME(label, ante, cons)
`define ALU8F_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/alu8f_pkg.sv -----
package alu8f_pkg;

    localparam int FUNC_W = 6;
    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int BIDX_W = 3;
    localparam int FLAG_W = 4;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 6'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADC   = 6'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUB   = 6'd2;
    localparam logic [FUNC_W-1:0] FUNC_SBC   = 6'd3;
    localparam logic [FUNC_W-1:0] FUNC_AND   = 6'd4;
    localparam logic [FUNC_W-1:0] FUNC_XOR   = 6'd5;
    localparam logic [FUNC_W-1:0] FUNC_OR    = 6'd6;
    localparam logic [FUNC_W-1:0] FUNC_CP    = 6'd7;
    localparam logic [FUNC_W-1:0] FUNC_INC8  = 6'd8;
    localparam logic [FUNC_W-1:0] FUNC_DEC8  = 6'd9;
    localparam logic [FUNC_W-1:0] FUNC_DAA   = 6'd10;
    localparam logic [FUNC_W-1:0] FUNC_CPL   = 6'd11;
    localparam logic [FUNC_W-1:0] FUNC_SCF   = 6'd12;
    localparam logic [FUNC_W-1:0] FUNC_CCF   = 6'd13;
    localparam logic [FUNC_W-1:0] FUNC_RLCA  = 6'd14;
    localparam logic [FUNC_W-1:0] FUNC_RRCA  = 6'd15;
    localparam logic [FUNC_W-1:0] FUNC_RLA   = 6'd16;
    localparam logic [FUNC_W-1:0] FUNC_RRA   = 6'd17;
    localparam logic [FUNC_W-1:0] FUNC_RLC   = 6'd18;
    localparam logic [FUNC_W-1:0] FUNC_RRC   = 6'd19;
    localparam logic [FUNC_W-1:0] FUNC_RL    = 6'd20;
    localparam logic [FUNC_W-1:0] FUNC_RR    = 6'd21;
    localparam logic [FUNC_W-1:0] FUNC_SLA   = 6'd22;
    localparam logic [FUNC_W-1:0] FUNC_SRA   = 6'd23;
    localparam logic [FUNC_W-1:0] FUNC_SWAP  = 6'd24;
    localparam logic [FUNC_W-1:0] FUNC_SRL   = 6'd25;
    localparam logic [FUNC_W-1:0] FUNC_BIT   = 6'd26;
    localparam logic [FUNC_W-1:0] FUNC_RES   = 6'd27;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 6'd28;
    localparam logic [FUNC_W-1:0] FUNC_INC16 = 6'd29;
    localparam logic [FUNC_W-1:0] FUNC_DEC16 = 6'd30;
    localparam logic [FUNC_W-1:0] FUNC_ADD16 = 6'd31;
    localparam logic [FUNC_W-1:0] FUNC_ADDSP = 6'd32;

    localparam logic [BYTE_W-1:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LIMIT    = 8'h99;
    localparam logic [3:0]        NIBBLE_LIMIT = 4'd9;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [BIDX_W-1:0] bit_index;
        logic [FLAG_W-1:0] flags_in;
    } alu8f_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic [FLAG_W-1:0] flags;
        logic              write_result;
    } alu8f_rsp_t;

endpackage

// ----- design/alu8f_exec.sv -----
module alu8f_exec
    import alu8f_pkg::*;
(
    input  alu8f_req_t req,
    output alu8f_rsp_t rsp
);

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              cin;
    logic              nin;
    logic              hin;
    logic              carry_t;
    logic [BYTE_W:0]   sum9;
    logic [4:0]        sum5;
    logic [BYTE_W:0]   diff9;
    logic [4:0]        diff5;
    logic [BYTE_W-1:0] inc8;
    logic [BYTE_W-1:0] dec8;
    logic [BYTE_W-1:0] daa_adj;
    logic              daa_c;
    logic [BYTE_W-1:0] daa_res;
    logic [BYTE_W-1:0] bit_mask;
    logic [BYTE_W-1:0] r8;
    logic [WORD_W:0]   sum17;
    logic [12:0]       sum13;
    logic [WORD_W-1:0] sp_sum;
    logic [4:0]        sp_h;
    logic [BYTE_W:0]   sp_c;
    logic [WORD_W-1:0] res;
    logic [FLAG_W-1:0] fo;
    logic              wr;

    assign a   = req.operand_a[BYTE_W-1:0];
    assign b   = req.operand_b[BYTE_W-1:0];
    assign cin = req.flags_in[FLAG_C];
    assign nin = req.flags_in[FLAG_N];
    assign hin = req.flags_in[FLAG_H];

    // carry in only for adc and sbc
    assign carry_t = (req.func == FUNC_ADC || req.func == FUNC_SBC) ? cin : 1'b0;

    assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, carry_t};
    assign sum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_t};
    assign diff9 = {1'b0, a} - {1'b0, b} - {8'd0, carry_t};
    assign diff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_t};
    assign inc8  = a + 8'd1;
    assign dec8  = a - 8'd1;

    always_comb
    begin
        daa_adj = '0;
        daa_c   = cin;
        if (hin || (!nin && a[3:0] > NIBBLE_LIMIT))
        begin
            daa_adj = DAA_LOW_ADJ;
        end
        if (cin || (!nin && a > DAA_LIMIT))
        begin
            daa_adj = daa_adj | DAA_HIGH_ADJ;
            daa_c   = 1'b1;
        end
    end

    assign daa_res  = nin ? (a - daa_adj) : (a + daa_adj);
    assign bit_mask = 8'd1 << req.bit_index;

    assign sum17  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
    assign sum13  = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
    assign sp_sum = req.operand_a + {{BYTE_W{b[7]}}, b};
    assign sp_h   = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};
    assign sp_c   = {1'b0, req.operand_a[7:0]} + {1'b0, b};

    always_comb
    begin
        r8  = '0;
        res = '0;
        fo  = req.flags_in;
        wr  = 1'b1;
        unique case (req.func) inside
            FUNC_ADD, FUNC_ADC:
            begin
                r8 = sum9[7:0];
                fo = {r8 == 8'd0, 1'b0, sum5[4], sum9[8]};
            end
            FUNC_SUB, FUNC_SBC:
            begin
                r8 = diff9[7:0];
                fo = {r8 == 8'd0, 1'b1, diff5[4], diff9[8]};
            end
            FUNC_CP:
            begin
                fo = {diff9[7:0] == 8'd0, 1'b1, diff5[4], diff9[8]};
                wr = 1'b0;
            end
            FUNC_AND:
            begin
                r8 = a & b;
                fo = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            FUNC_XOR:
            begin
                r8 = a ^ b;
                fo = {r8 == 8'd0, 3'b000};
            end
            FUNC_OR:
            begin
                r8 = a | b;
                fo = {r8 == 8'd0, 3'b000};
            end
            FUNC_INC8:
            begin
                r8 = inc8;
                fo = {r8 == 8'd0, 1'b0, r8[3:0] == 4'h0, cin};
            end
            FUNC_DEC8:
            begin
                r8 = dec8;
                fo = {r8 == 8'd0, 1'b1, r8[3:0] == 4'hF, cin};
            end
            FUNC_DAA:
            begin
                r8 = daa_res;
                fo = {r8 == 8'd0, nin, 1'b0, daa_c};
            end
            FUNC_CPL:
            begin
                r8 = ~a;
                fo = {req.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
            end
            FUNC_SCF:
            begin
                fo = {req.flags_in[FLAG_Z], 3'b001};
                wr = 1'b0;
            end
            FUNC_CCF:
            begin
                fo = {req.flags_in[FLAG_Z], 2'b00, ~cin};
                wr = 1'b0;
            end
            FUNC_RLCA:
            begin
                r8 = {a[6:0], a[7]};
                fo = {3'b000, a[7]};
            end
            FUNC_RRCA:
            begin
                r8 = {a[0], a[7:1]};
                fo = {3'b000, a[0]};
            end
            FUNC_RLA:
            begin
                r8 = {a[6:0], cin};
                fo = {3'b000, a[7]};
            end
            FUNC_RRA:
            begin
                r8 = {cin, a[7:1]};
                fo = {3'b000, a[0]};
            end
            FUNC_RLC:
            begin
                r8 = {a[6:0], a[7]};
                fo = {r8 == 8'd0, 2'b00, a[7]};
            end
            FUNC_RRC:
            begin
                r8 = {a[0], a[7:1]};
                fo = {r8 == 8'd0, 2'b00, a[0]};
            end
            FUNC_RL:
            begin
                r8 = {a[6:0], cin};
                fo = {r8 == 8'd0, 2'b00, a[7]};
            end
            FUNC_RR:
            begin
                r8 = {cin, a[7:1]};
                fo = {r8 == 8'd0, 2'b00, a[0]};
            end
            FUNC_SLA:
            begin
                r8 = {a[6:0], 1'b0};
                fo = {r8 == 8'd0, 2'b00, a[7]};
            end
            FUNC_SRA:
            begin
                r8 = {a[7], a[7:1]};
                fo = {r8 == 8'd0, 2'b00, a[0]};
            end
            FUNC_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                fo = {r8 == 8'd0, 3'b000};
            end
            FUNC_SRL:
            begin
                r8 = {1'b0, a[7:1]};
                fo = {r8 == 8'd0, 2'b00, a[0]};
            end
            FUNC_BIT:
            begin
                fo = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
                wr = 1'b0;
            end
            FUNC_RES:
            begin
                r8 = a & ~bit_mask;
            end
            FUNC_SET:
            begin
                r8 = a | bit_mask;
            end
            FUNC_INC16:
            begin
                res = req.operand_a + 16'd1;
            end
            FUNC_DEC16:
            begin
                res = req.operand_a - 16'd1;
            end
            FUNC_ADD16:
            begin
                res = sum17[WORD_W-1:0];
                fo  = {req.flags_in[FLAG_Z], 1'b0, sum13[12], sum17[WORD_W]};
            end
            FUNC_ADDSP:
            begin
                res = sp_sum;
                fo  = {2'b00, sp_h[4], sp_c[BYTE_W]};
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase
        // byte results land in the low half
        if (req.func < FUNC_INC16)
        begin
            res = {8'd0, r8};
        end
    end

    assign rsp.result       = res;
    assign rsp.flags        = fo;
    assign rsp.write_result = wr;

endmodule

// ----- design/eight_bit_cpu_alu_with_flags_core.sv -----
// Eight-bit cpu alu with flags. Each transfer on the input channel carries an
// operation, two operands, a bit index and the incoming Z N H C flags, and
// produces exactly one transfer on the output channel with the result, the new
// flags and the write enable for the destination. The block is an input
// register, one pass of combinational alu logic and a result register, so an
// operation is held first in the input register and then in the result
// register before its result can transfer; it sustains one transfer
// per cycle, and the input stalls only while both registers are full and the
// output is stalled. There are no configuration registers and no state kept
// between operations.
`include "eight_bit_cpu_alu_with_flags_core_defines.svh"

module eight_bit_cpu_alu_with_flags_core
    import alu8f_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [WORD_W-1:0] operand_a,
    input  logic [WORD_W-1:0] operand_b,
    input  logic [BIDX_W-1:0] bit_index,
    input  logic [FLAG_W-1:0] flags_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] result,
    output logic [FLAG_W-1:0] flags_out,
    output logic              write_result
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    alu8f_req_t s1_req_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    alu8f_rsp_t out_rsp_reg;
    alu8f_rsp_t alu_rsp;
    logic       out_open;
    logic       s1_open;

    assign out_open = !out_valid_reg || !out_stall;
    assign s1_open  = !s1_valid_reg || out_open;
    assign in_stall = !s1_open;

    assign s1_valid_next  = s1_open ? in_valid : s1_valid_reg;
    assign out_valid_next = out_open ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_open && in_valid)
        begin
            s1_req_reg <= '{func:      func,
                            operand_a: operand_a,
                            operand_b: operand_b,
                            bit_index: bit_index,
                            flags_in:  flags_in};
        end
        if (out_open && s1_valid_reg)
        begin
            out_rsp_reg <= alu_rsp;
        end
    end

    alu8f_exec u_exec
    (
        .req (s1_req_reg),
        .rsp (alu_rsp)
    );

    assign out_valid    = out_valid_reg;
    assign result       = out_rsp_reg.result;
    assign flags_out    = out_rsp_reg.flags;
    assign write_result = out_rsp_reg.write_result;

    `ALU8F_ASSERT_SAME(a_stall_only_when_full, in_stall, s1_valid_reg && out_valid_reg && out_stall)
    `ALU8F_ASSERT_NEXT(a_stage_moves_on, s1_valid_reg && out_open, out_valid_reg)
    `ALU8F_ASSERT_SAME(a_no_write_zero_result, out_valid_reg && !write_result, result == 16'd0)
    `ALU8F_ASSERT_SAME(a_out_from_stage, $rose(out_valid_reg), $past(s1_valid_reg))

endmodule

// ----- test/eight_bit_cpu_alu_with_flags_core_tb.sv -----
module eight_bit_cpu_alu_with_flags_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alu8f_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_LO = 6'd33;
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_HI = 6'd63;
    localparam int RANDOM_OPS = 1200;
    localparam int HOLD_CYCLES = 64;
    localparam int NUM_DIR = 37;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [BIDX_W-1:0] bi;
        logic [FLAG_W-1:0] fl;
        logic              typed;
        logic [WORD_W-1:0] exp_res;
        logic [FLAG_W-1:0] exp_fl;
        logic              exp_wr;
    } dir_row_t;

    // op, a, b, bit, flags, typed, result, flags, write
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        '{FUNC_ADD,   16'h00FF, 16'h0001, 3'd0, 4'h0, 1'b1, 16'h0000, 4'hB, 1'b1},
        '{FUNC_ADC,   16'h00FF, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0000, 4'hB, 1'b1},
        '{FUNC_SUB,   16'h0000, 16'h0001, 3'd0, 4'h0, 1'b1, 16'h00FF, 4'h7, 1'b1},
        '{FUNC_SBC,   16'h0010, 16'h000F, 3'd0, 4'h1, 1'b1, 16'h0000, 4'hE, 1'b1},
        '{FUNC_AND,   16'h00F0, 16'h000F, 3'd0, 4'h0, 1'b1, 16'h0000, 4'hA, 1'b1},
        '{FUNC_XOR,   16'hFFFF, 16'hFFFF, 3'd0, 4'hF, 1'b1, 16'h0000, 4'h8, 1'b1},
        '{FUNC_OR,    16'h00A5, 16'h005A, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
        '{FUNC_CP,    16'h0042, 16'h0042, 3'd0, 4'h0, 1'b1, 16'h0000, 4'hC, 1'b0},
        '{FUNC_INC8,  16'h00FF, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0000, 4'hB, 1'b1},
        '{FUNC_DEC8,  16'h0000, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h00FF, 4'h6, 1'b1},
        '{FUNC_DAA,   16'h009A, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h9, 1'b1},
        '{FUNC_DAA,   16'h000F, 16'h0000, 3'd0, 4'h6, 1'b0, 16'h0000, 4'h0, 1'b0},
        '{FUNC_CPL,   16'h0000, 16'h0000, 3'd0, 4'h9, 1'b1, 16'h00FF, 4'hF, 1'b1},
        '{FUNC_SCF,   16'h0000, 16'h0000, 3'd0, 4'h6, 1'b1, 16'h0000, 4'h1, 1'b0},
        '{FUNC_CCF,   16'h0000, 16'h0000, 3'd0, 4'h9, 1'b1, 16'h0000, 4'h8, 1'b0},
        '{FUNC_RLCA,  16'h0080, 16'h0000, 3'd0, 4'h8, 1'b1, 16'h0001, 4'h1, 1'b1},
        '{FUNC_RRCA,  16'h0000, 16'h0000, 3'd0, 4'h8, 1'b1, 16'h0000, 4'h0, 1'b1},
        '{FUNC_RLA,   16'h0080, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h1, 1'b1},
        '{FUNC_RRA,   16'h0001, 16'h0000, 3'd0, 4'h1, 1'b0, 16'h0000, 4'h0, 1'b0},
        '{FUNC_RLC,   16'h0000, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h8, 1'b1},
        '{FUNC_RRC,   16'h0001, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
        '{FUNC_RL,    16'h0080, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h9, 1'b1},
        '{FUNC_RR,    16'h0001, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h9, 1'b1},
        '{FUNC_SLA,   16'h0080, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h9, 1'b1},
        '{FUNC_SRA,   16'h0081, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
        '{FUNC_SWAP,  16'h00F0, 16'h0000, 3'd0, 4'hF, 1'b0, 16'h0000, 4'h0, 1'b0},
        '{FUNC_SRL,   16'h0001, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h9, 1'b1},
        '{FUNC_BIT,   16'h007F, 16'h0000, 3'd7, 4'h1, 1'b1, 16'h0000, 4'hB, 1'b0},
        '{FUNC_RES,   16'hFFFF, 16'h0000, 3'd7, 4'hF, 1'b0, 16'h0000, 4'h0, 1'b0},
        '{FUNC_SET,   16'h0000, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
        '{FUNC_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'hF, 1'b1, 16'h0000, 4'hF, 1'b1},
        '{FUNC_DEC16, 16'h0000, 16'h0000, 3'd0, 4'h0, 1'b1, 16'hFFFF, 4'h0, 1'b1},
        '{FUNC_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'h8, 1'b1, 16'h0000, 4'hB, 1'b1},
        '{FUNC_ADDSP, 16'hFFF8, 16'h0008, 3'd0, 4'hC, 1'b1, 16'h0000, 4'h3, 1'b1},
        '{FUNC_ADDSP, 16'h0000, 16'h0080, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
        '{FUNC_UNKNOWN_LO, 16'h1234, 16'h5678, 3'd3, 4'hA,
          1'b1, 16'h0000, 4'hA, 1'b0},
        '{FUNC_UNKNOWN_HI, 16'hFFFF, 16'hFFFF, 3'd7, 4'h5,
          1'b1, 16'h0000, 4'h5, 1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
    logic [BIDX_W-1:0] bit_index;
    logic [FLAG_W-1:0] flags_in;
    logic              out_valid;
    logic              out_stall;
    logic [WORD_W-1:0] result;
    logic [FLAG_W-1:0] flags_out;
    logic              write_result;

    alu8f_rsp_t pending_results[$];
    int         error_count = 0;
    int         send_idle_pct = 38;
    int         recv_stall_pct = 51;
    bit         hold_request = 1'b0;
    int         hold_left = 0;

    eight_bit_cpu_alu_with_flags_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .bit_index    (bit_index),
        .flags_in     (flags_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result),
        .flags_out    (flags_out),
        .write_result (write_result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic alu8f_rsp_t alu_expected(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] wa,
                                                logic [WORD_W-1:0] wb, logic [BIDX_W-1:0] bi,
                                                logic [FLAG_W-1:0] fin);
        int unsigned a, b, a16, b16, ci, t, res, adj, off;
        logic [FLAG_W-1:0] fo;
        logic wr;
        logic cy;
        alu8f_rsp_t rsp;
        a16 = 32'(wa);
        b16 = 32'(wb);
        a = 32'(wa[7:0]);
        b = 32'(wb[7:0]);
        ci = 32'(fin[FLAG_C]);
        res = 0;
        fo = fin;
        wr = 1'b1;
        case (f)
            FUNC_ADD, FUNC_ADC:
            begin
                t = (f == FUNC_ADC) ? ci : 0;
                res = (a + b + t) & 'hFF;
                fo = {res == 0, 1'b0, (a & 'hF) + (b & 'hF) + t > 'hF, a + b + t > 'hFF};
            end
            FUNC_SUB, FUNC_SBC, FUNC_CP:
            begin
                t = (f == FUNC_SBC) ? ci : 0;
                res = (a - b - t) & 'hFF;
                fo = {res == 0, 1'b1, (a & 'hF) < (b & 'hF) + t, a < b + t};
                if (f == FUNC_CP)
                begin
                    res = 0;
                    wr = 1'b0;
                end
            end
            FUNC_AND:
            begin
                res = a & b;
                fo = {res == 0, 1'b0, 1'b1, 1'b0};
            end
            FUNC_XOR:
            begin
                res = a ^ b;
                fo = {res == 0, 3'b000};
            end
            FUNC_OR:
            begin
                res = a | b;
                fo = {res == 0, 3'b000};
            end
            FUNC_INC8:
            begin
                res = (a + 1) & 'hFF;
                fo = {res == 0, 1'b0, (res & 'hF) == 0, fin[FLAG_C]};
            end
            FUNC_DEC8:
            begin
                res = (a - 1) & 'hFF;
                fo = {res == 0, 1'b1, (res & 'hF) == 'hF, fin[FLAG_C]};
            end
            FUNC_DAA:
            begin
                adj = 0;
                cy = fin[FLAG_C];
                if (fin[FLAG_H] || (!fin[FLAG_N] && (a & 'hF) > 32'(NIBBLE_LIMIT)))
                    adj = 32'(DAA_LOW_ADJ);
                if (fin[FLAG_C] || (!fin[FLAG_N] && a > 32'(DAA_LIMIT)))
                begin
                    adj = adj | 32'(DAA_HIGH_ADJ);
                    cy = 1'b1;
                end
                res = (fin[FLAG_N] ? a - adj : a + adj) & 'hFF;
                fo = {res == 0, fin[FLAG_N], 1'b0, cy};
            end
            FUNC_CPL:
            begin
                res = ~a & 'hFF;
                fo = {fin[FLAG_Z], 1'b1, 1'b1, fin[FLAG_C]};
            end
            FUNC_SCF:
            begin
                wr = 1'b0;
                fo = {fin[FLAG_Z], 3'b001};
            end
            FUNC_CCF:
            begin
                wr = 1'b0;
                fo = {fin[FLAG_Z], 2'b00, ~fin[FLAG_C]};
            end
            FUNC_RLCA, FUNC_RLC:
            begin
                res = ((a << 1) | (a >> 7)) & 'hFF;
                fo = {(f == FUNC_RLC) && (res == 0), 2'b00, wa[7]};
            end
            FUNC_RRCA, FUNC_RRC:
            begin
                res = ((a >> 1) | (a << 7)) & 'hFF;
                fo = {(f == FUNC_RRC) && (res == 0), 2'b00, wa[0]};
            end
            FUNC_RLA, FUNC_RL:
            begin
                res = ((a << 1) | ci) & 'hFF;
                fo = {(f == FUNC_RL) && (res == 0), 2'b00, wa[7]};
            end
            FUNC_RRA, FUNC_RR:
            begin
                res = (a >> 1) | (ci << 7);
                fo = {(f == FUNC_RR) && (res == 0), 2'b00, wa[0]};
            end
            FUNC_SLA:
            begin
                res = (a << 1) & 'hFF;
                fo = {res == 0, 2'b00, wa[7]};
            end
            FUNC_SRA:
            begin
                res = (a >> 1) | (a & 'h80);
                fo = {res == 0, 2'b00, wa[0]};
            end
            FUNC_SWAP:
            begin
                res = ((a >> 4) | (a << 4)) & 'hFF;
                fo = {res == 0, 3'b000};
            end
            FUNC_SRL:
            begin
                res = a >> 1;
                fo = {res == 0, 2'b00, wa[0]};
            end
            FUNC_BIT:
            begin
                wr = 1'b0;
                fo = {wa[bi] == 1'b0, 1'b0, 1'b1, fin[FLAG_C]};
            end
            FUNC_RES:
                res = a & ~(32'd1 << bi) & 'hFF;
            FUNC_SET:
                res = a | (32'd1 << bi);
            FUNC_INC16:
                res = (a16 + 1) & 'hFFFF;
            FUNC_DEC16:
                res = (a16 - 1) & 'hFFFF;
            FUNC_ADD16:
            begin
                res = (a16 + b16) & 'hFFFF;
                fo = {fin[FLAG_Z], 1'b0, (a16 & 'hFFF) + (b16 & 'hFFF) >= 'h1000,
                      a16 + b16 >= 'h10000};
            end
            FUNC_ADDSP:
            begin
                off = wb[7] ? (b | 'hFF00) : b;
                res = (a16 + off) & 'hFFFF;
                fo = {2'b00, (a16 & 'hF) + (b & 'hF) >= 'h10, (a16 & 'hFF) + b >= 'h100};
            end
            default:
                wr = 1'b0;
        endcase
        rsp.result = res[WORD_W-1:0];
        rsp.flags = fo;
        rsp.write_result = wr;
        return rsp;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {8'h00, 8'($urandom_range(255))};
            3: return {8'($urandom_range(255)), 8'hFF};
            default: return 16'($urandom);
        endcase
    endfunction

    // holds the payload until the block takes it
    task automatic offer_op(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] wa,
                            input logic [WORD_W-1:0] wb, input logic [BIDX_W-1:0] bi,
                            input logic [FLAG_W-1:0] fin, input alu8f_rsp_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        operand_a <= wa;
        operand_b <= wb;
        bit_index <= bi;
        flags_in <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(want);
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("%0t mismatch on %s: expected %h actual %h", $time, what, want, got);
        error_count++;
    endtask

    initial
    begin
        dir_row_t row;
        alu8f_rsp_t want;
        logic [FUNC_W-1:0] f;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        operand_a = '0;
        operand_b = '0;
        bit_index = '0;
        flags_in = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
        begin
            row = DIR_ROWS[i];
            if (row.typed)
            begin
                want.result = row.exp_res;
                want.flags = row.exp_fl;
                want.write_result = row.exp_wr;
            end
            else
                want = alu_expected(row.op, row.a, row.b, row.bi, row.fl);
            offer_op(row.op, row.a, row.b, row.bi, row.fl, want);
        end

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == RANDOM_OPS / 3)
            begin
                send_idle_pct = 51;
                recv_stall_pct = 38;
            end
            if (n == 2 * RANDOM_OPS / 3)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                hold_request = 1'b1;
            end
            if ($urandom_range(99) < 8)
                f = 6'($urandom_range(FUNC_UNKNOWN_HI, FUNC_UNKNOWN_LO));
            else
                f = 6'($urandom_range(FUNC_ADDSP, FUNC_ADD));
            begin
                logic [WORD_W-1:0] wa, wb;
                logic [BIDX_W-1:0] bi;
                logic [FLAG_W-1:0] fin;
                wa = pick_word();
                wb = pick_word();
                bi = 3'($urandom_range(7));
                fin = 4'($urandom_range(15));
                offer_op(f, wa, wb, bi, fin, alu_expected(f, wa, wb, bi, fin));
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // receiver side, with one long hold-off to back the block up
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result transfers against the oldest expectation
    always @(posedge clk)
    begin
        alu8f_rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected transfer: expected none actual %h %h %b",
                         $time, result, flags_out, write_result);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.result)
                    report_mismatch("result", want.result, result);
                if (flags_out !== want.flags)
                    report_mismatch("flags_out", 16'(want.flags), 16'(flags_out));
                if (write_result !== want.write_result)
                    report_mismatch("write_result", 16'(want.write_result), 16'(write_result));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
